// ----- hdl/ple_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ple_pkg
// Shared sizes, command codes and the cell broadcast bus of the positional
// list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_LOCATE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_INSERT = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    // Broadcast to every cell. Capture samples the compare and select
    // results; ins and del shift the stored words.
    typedef struct packed {
        logic                  capture;
        logic                  ins;
        logic                  del;
        logic [IDX_W-1:0]      k;
        logic [DATA_WIDTH-1:0] key;
        logic [CNT_W-1:0]      count;
    } ple_bus_t;

    // Sign-extend (or truncate) an input value to the storage width.
    function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [VAL_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ple_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ple_req_if / ple_rsp_if
// Valid/ready channels carrying one request item and one result item.
// ---------------------------------------------------------------------------
interface ple_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, output cmd, output position, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input item_value,
                    output ready);
endinterface

interface ple_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         list_length;

    modport source (output valid, output ok, output read_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input ok, input read_value,
                    input found_position, input list_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words with get, locate, delete and insert commands.
// ---------------------------------------------------------------------------
// Sequence: the cells compare and select at the edge that accepts an item,
// and the edge that leaves the resolve state shifts the cells and loads the
// result register, which offers the result; a stalled result holds the
// resolve state. The engine takes a new item only after the last one has
// resolved, since the compare-then-shift sequence runs through one cell row.
// Reset: clears the length, the handshake and the result valid flag. Stored
// words are not cleared; only words below the length are ever read.
// ---------------------------------------------------------------------------
module positional_list_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    state_t                state_reg;
    state_t                state_next;

    // Request held across the resolve cycle.
    cmd_t                  cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] key_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Result register, which decouples the cell row from the sink.
    logic                  rsp_valid_reg;
    logic                  ok_reg;
    logic [VAL_W-1:0]      read_reg;
    logic [POS_W-1:0]      found_reg;
    logic [POS_W-1:0]      length_reg;

    ple_bus_t              bus;
    logic [DEPTH-1:0]      hit;
    logic [DATA_WIDTH-1:0] read_word;

    logic                  fire;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  in_range;
    logic                  ins_range;
    logic                  cmd_ok;
    logic [CNT_W-1:0]      found_idx;
    logic [POS_W-1:0]      req_k;
    logic [POS_W-1:0]      reg_k;

    ple_chain u_chain (
        .clk       (clk),
        .bus       (bus),
        .hit       (hit),
        .read_word (read_word)
    );

    // Position checks against the current length. A get or delete needs
    // 1..length; an insert needs 1..length+1 and room for one more word.
    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign in_range  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ins_range = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                       && (count_reg != CNT_W'(DEPTH));

    // First matching cell wins; scanning from the top lets the lowest
    // position overwrite the higher ones.
    always_comb
    begin
        found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found_idx = CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_GET:    cmd_ok = in_range;
            CMD_LOCATE: cmd_ok = |hit;
            CMD_DELETE: cmd_ok = in_range;
            CMD_INSERT: cmd_ok = ins_range;
            default:    cmd_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (fire && cmd_ok && (cmd_reg == CMD_DELETE))
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (fire && cmd_ok && (cmd_reg == CMD_INSERT))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // The resolve cycle completes only when the result register can take
    // the result.
    assign fire  = (state_reg == ST_RESOLVE) && (!rsp_valid_reg || rsp.ready);
    assign req_k = req.position - POS_W'(1);
    assign reg_k = pos_reg - POS_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller: the request handshake and the cell bus.
    // While idle the cells compare against the incoming item; while
    // resolving they are told to shift.
    always_comb
    begin
        req.ready   = 1'b0;
        bus.capture = 1'b0;
        bus.ins     = 1'b0;
        bus.del     = 1'b0;
        bus.k       = IDX_W'(reg_k);
        bus.key     = key_reg;
        bus.count   = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready   = 1'b1;
                bus.capture = req.valid;
                bus.k       = IDX_W'(req_k);
                bus.key     = to_data(req.item_value);
            end
            ST_RESOLVE:
            begin
                bus.ins = fire && cmd_ok && (cmd_reg == CMD_INSERT);
                bus.del = fire && cmd_ok && (cmd_reg == CMD_DELETE);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            pos_reg <= req.position;
            key_reg <= to_data(req.item_value);
        end
        if (fire)
        begin
            ok_reg     <= cmd_ok;
            read_reg   <= (cmd_ok && ((cmd_reg == CMD_GET) || (cmd_reg == CMD_DELETE)))
                          ? VAL_W'(read_word) : '0;
            found_reg  <= (cmd_reg == CMD_LOCATE) ? POS_W'(found_idx) : '0;
            length_reg <= POS_W'(count_next);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.read_value     = read_reg;
    assign rsp.found_position = found_reg;
    assign rsp.list_length    = length_reg;

endmodule
`default_nettype wire

// ----- hdl/ple_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ple_cell
// One list slot: holds a word, compares it with the broadcast key and
// takes its neighbor's word when the list shifts.
// ---------------------------------------------------------------------------
module ple_cell (
    input  wire logic                           clk,
    input  wire logic [ple_pkg::IDX_W-1:0]      idx,
    input  wire ple_pkg::ple_bus_t              bus,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0] left_value,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0] right_value,
    output logic      [ple_pkg::DATA_WIDTH-1:0] value,
    output logic                                hit,
    output logic      [ple_pkg::DATA_WIDTH-1:0] pick_value
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  hit_reg;
    logic [DATA_WIDTH-1:0] pick_reg;
    logic                  in_use;

    assign in_use = CNT_W'(idx) < bus.count;

    always_comb
    begin
        value_next = value_reg;
        if (bus.ins && (idx > bus.k))
        begin
            value_next = left_value;
        end
        else if (bus.ins && (idx == bus.k))
        begin
            value_next = bus.key;
        end
        else if (bus.del && (idx >= bus.k))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (bus.capture)
        begin
            hit_reg  <= in_use && (value_reg == bus.key);
            pick_reg <= (idx == bus.k) ? value_reg : '0;
        end
    end

    assign value      = value_reg;
    assign hit        = hit_reg;
    assign pick_value = pick_reg;

endmodule
`default_nettype wire

// ----- hdl/ple_chain.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ple_chain
// The row of list cells, linked to both neighbors, with the merge of the
// selected word.
// ---------------------------------------------------------------------------
module ple_chain (
    input  wire logic                           clk,
    input  wire ple_pkg::ple_bus_t              bus,
    output logic      [ple_pkg::DEPTH-1:0]      hit,
    output logic      [ple_pkg::DATA_WIDTH-1:0] read_word
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] value [DEPTH];
    logic [DATA_WIDTH-1:0] pick  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = value[i+1];
        end

        ple_cell u_cell (
            .clk         (clk),
            .idx         (IDX_W'(i)),
            .bus         (bus),
            .left_value  (left_w),
            .right_value (right_w),
            .value       (value[i]),
            .hit         (hit[i]),
            .pick_value  (pick[i])
        );
    end

    // At most one cell is selected, so an OR merge yields its word.
    always_comb
    begin
        read_word = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            read_word = read_word | pick[j];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ple_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to its top level.
// ---------------------------------------------------------------------------
module ple_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       rsp_ok,
    input wire logic [31:0] rsp_read_value,
    input wire logic [6:0] rsp_found_position,
    input wire logic [6:0] rsp_list_length
);
    import ple_pkg::*;

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // The engine works on one item at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while one is in progress");

    // A failed command reports no value and no position.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> (rsp_read_value == 32'd0) && (rsp_found_position == 7'd0))
        else $error("failed command carries data");

    // The length never exceeds the capacity.
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_list_length) <= DEPTH))
        else $error("list length beyond capacity");

    // A found position lies inside the list.
    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_found_position != 7'd0) |-> (rsp_found_position <= rsp_list_length))
        else $error("found position beyond list length");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_read_value     (rsp.read_value),
    .rsp_found_position (rsp.found_position),
    .rsp_list_length    (rsp.list_length)
);
`default_nettype wire

// ----- tb/tb_positional_list_engine.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A queue-fed driver
// sends get, locate, delete and insert requests, and a predictor keeps its
// own copy of the list. A monitor checks every result, field by field,
// against the oldest prediction, under four idling and stalling mixes.
// ---------------------------------------------------------------------------
module tb_positional_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // The run is cut off here if the results stop coming. A correct run
    // needs only a small fraction of this.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    // One request item, as queued for the driver.
    typedef struct {
        cmd_t               cmd;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } list_request_t;

    // One result item, as predicted for the monitor.
    typedef struct {
        logic        ok;
        logic [31:0] read_value;
        logic [6:0]  found_position;
        logic [6:0]  list_length;
    } list_result_t;

    // This pool holds the extremes and a few small values. Drawing from it
    // gives duplicates in the list, so locate often hits, and hits on the
    // first of several matches.
    localparam logic signed [31:0] VALUE_POOL [12] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
        32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 32'shFFFF_FFFE,
        32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0064, 32'sh7FFF_FFFE
    };

    logic clk;
    logic rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    positional_list_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // The request items that still wait for the driver.
    list_request_t pending_requests[$];
    // The results that the predictor has worked out and that have not arrived.
    list_result_t expected_results[$];
    // The predictor's own copy of the list, first entry at index 0.
    logic [DATA_WIDTH-1:0] list_words[$];

    // The generator tracks the list length that its queued items will leave,
    // so that it can aim most positions inside the valid range.
    int gen_length = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic req_taken = 1'b0;

    int cycle_count     = 0;
    int error_count     = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int locate_hits     = 0;
    int empty_visits    = 0;
    int peak_length     = 0;

    // -----------------------------------------------------------------------
    // Clock and cycle watchdog.
    // -----------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still expected.",
                 cycle_count, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Every input of the block is given a known value from time zero on.
    initial begin
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_GET;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        rsp_ch.ready      = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Checking.
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // The list model. It works out the result of one accepted request and
    // updates the list the way the block must.
    task automatic apply_list_command(input cmd_t cmd, input logic [6:0] position,
                                      input logic signed [31:0] item_value);
        list_result_t          res;
        logic [DATA_WIDTH-1:0] word;
        int                    length;
        int                    pos;
        res    = '{ok: 1'b0, read_value: '0, found_position: '0, list_length: '0};
        word   = DATA_WIDTH'(item_value);
        length = list_words.size();
        pos    = int'(position);
        case (cmd)
            CMD_GET:
                if (pos >= 1 && pos <= length) begin
                    res.ok         = 1'b1;
                    res.read_value = 32'(list_words[pos-1]);
                end
            CMD_LOCATE:
                // The first match wins, so the scan stops at the lowest position.
                for (int k = 0; k < length; k++) begin
                    if (list_words[k] == word) begin
                        res.ok             = 1'b1;
                        res.found_position = 7'(k + 1);
                        locate_hits++;
                        break;
                    end
                end
            CMD_DELETE:
                if (pos >= 1 && pos <= length) begin
                    res.ok         = 1'b1;
                    res.read_value = 32'(list_words[pos-1]);
                    list_words.delete(pos - 1);
                    if (list_words.size() == 0)
                        empty_visits++;
                end
            default:
                // An insert may go anywhere from the head to just past the
                // tail, but never into a full list.
                if (length == DEPTH) begin
                    full_refusals++;
                end else if (pos >= 1 && pos <= length + 1) begin
                    res.ok = 1'b1;
                    list_words.insert(pos - 1, word);
                end
        endcase
        res.list_length = 7'(list_words.size());
        if (list_words.size() > peak_length)
            peak_length = list_words.size();
        expected_results.push_back(res);
    endtask

    task automatic check_list_result();
        list_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result arrived with none expected (ok=%0b len=%0d)",
                                      rsp_ch.ok, rsp_ch.list_length));
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (rsp_ch.ok !== want.ok)
            report_mismatch($sformatf("result %0d ok %0b, expected %0b",
                                      results_checked, rsp_ch.ok, want.ok));
        if (rsp_ch.read_value !== want.read_value)
            report_mismatch($sformatf("result %0d read_value %0d, expected %0d",
                                      results_checked, rsp_ch.read_value,
                                      $signed(want.read_value)));
        if (rsp_ch.found_position !== want.found_position)
            report_mismatch($sformatf("result %0d found_position %0d, expected %0d",
                                      results_checked, rsp_ch.found_position,
                                      want.found_position));
        if (rsp_ch.list_length !== want.list_length)
            report_mismatch($sformatf("result %0d list_length %0d, expected %0d",
                                      results_checked, rsp_ch.list_length,
                                      want.list_length));
    endtask

    // Monitor. Both channels are sampled at the rising edge, before the block
    // has updated anything in that time step.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
                apply_list_command(cmd_t'(req_ch.cmd), req_ch.position, req_ch.item_value);
            if (rsp_ch.valid && rsp_ch.ready)
                check_list_result();
        end
    end

    // -----------------------------------------------------------------------
    // Driver. Inputs change at the falling edge. A raised valid is held with
    // its payload until the item has been taken; the sender idles at random
    // only between items. The receiver's ready is drawn anew each cycle.
    // -----------------------------------------------------------------------
    always @(negedge clk) begin
        list_request_t next_req;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.cmd        <= next_req.cmd;
                req_ch.position   <= next_req.position;
                req_ch.item_value <= next_req.item_value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    // Queues one item and keeps the generator's length in step with it.
    task automatic queue_item(input cmd_t cmd, input int position,
                              input logic signed [31:0] item_value);
        list_request_t item;
        item.cmd        = cmd;
        item.position   = 7'(position);
        item.item_value = item_value;
        pending_requests.push_back(item);
        if (cmd == CMD_INSERT && position >= 1 && position <= gen_length + 1
                && gen_length < DEPTH)
            gen_length++;
        else if (cmd == CMD_DELETE && position >= 1 && position <= gen_length)
            gen_length--;
    endtask

    // Head, tail or anywhere in between, with the ends favored.
    function automatic int pick_position(input int highest);
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return highest;
            default: return $urandom_range(1, highest);
        endcase
    endfunction

    // A run of random items. The insert and delete shares steer the list
    // toward full or toward empty; the rest are gets and locates.
    task automatic queue_random(input int count, input int ins_pct, input int del_pct);
        int                 roll;
        int                 highest;
        int                 position;
        cmd_t               cmd;
        logic signed [31:0] item_value;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                cmd = CMD_INSERT;
            else if (roll < ins_pct + del_pct)
                cmd = CMD_DELETE;
            else
                cmd = roll[0] ? CMD_GET : CMD_LOCATE;
            highest = (cmd == CMD_INSERT) ? gen_length + 1 : gen_length;
            // A share of positions is pure noise over the whole field, which
            // covers zero, positions past the end and every bit.
            if (highest == 0 || $urandom_range(0, 99) < 12)
                position = $urandom_range(0, 127);
            else
                position = pick_position(highest);
            if ($urandom_range(0, 1))
                item_value = VALUE_POOL[$urandom_range(0, 11)];
            else
                item_value = $urandom;
            queue_item(cmd, position, item_value);
        end
    endtask

    // Directed opening: an empty list, bad positions on every command, the
    // value extremes, inserts at head, middle and tail, a duplicate so that
    // locate must pick the first match, and deletes at each end.
    task automatic queue_directed();
        queue_item(CMD_GET,    1,   32'sd0);
        queue_item(CMD_DELETE, 1,   32'sd0);
        queue_item(CMD_LOCATE, 0,   32'sd0);
        queue_item(CMD_INSERT, 0,   32'sd9);
        queue_item(CMD_INSERT, 2,   32'sd9);
        queue_item(CMD_INSERT, 1,   32'sh7FFF_FFFF);
        queue_item(CMD_INSERT, 2,   32'sh8000_0000);
        queue_item(CMD_INSERT, 1,   -32'sd1);
        queue_item(CMD_INSERT, 2,   32'sd0);
        queue_item(CMD_INSERT, 127, 32'sd5);
        queue_item(CMD_GET,    1,   32'sd0);
        queue_item(CMD_GET,    4,   32'sd0);
        queue_item(CMD_GET,    5,   32'sd0);
        queue_item(CMD_GET,    0,   32'sd0);
        queue_item(CMD_GET,    127, 32'sd0);
        queue_item(CMD_LOCATE, 0,   32'sh8000_0000);
        queue_item(CMD_INSERT, 3,   -32'sd1);
        queue_item(CMD_LOCATE, 0,   -32'sd1);
        queue_item(CMD_LOCATE, 0,   32'sd12345);
        queue_item(CMD_DELETE, 0,   32'sd0);
        queue_item(CMD_DELETE, 6,   32'sd0);
        queue_item(CMD_DELETE, 5,   32'sd0);
        queue_item(CMD_DELETE, 1,   32'sd0);
        queue_item(CMD_DELETE, 2,   32'sd0);
        queue_item(CMD_LOCATE, 127, 32'sh7FFF_FFFF);
    endtask

    // Waits until every queued item has been sent and every result checked,
    // then lets the clock run on so a stray extra result would still be caught.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Each phase fills the list until inserts are refused at full, then
        // drains it back to empty, under its own mix of sender gaps and
        // receiver stalls. The first phase runs flat out and opens with the
        // directed items.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (phase == 0)
                queue_directed();
            queue_random(100, 80, 5);
            queue_random(85, 5, 80);
            wait_until_drained();
        end

        $display("Checked %0d results over four idle/stall mixes; peak length %0d of %0d.",
                 results_checked, peak_length, DEPTH);
        $display("Inserts refused at full: %0d, locate hits: %0d, drains to empty: %0d.",
                 full_refusals, locate_hits, empty_visits);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/ple_pkg.sv
hdl/ple_if.sv
hdl/ple_cell.sv
hdl/ple_chain.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
tb/tb_positional_list_engine.sv
